// ----- hdl/vdi_pkg.sv -----
// ----------------------------------------------------------------------------
// vdi_pkg
// Types and constants shared by the vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int          VIDX_W     = 10;
    localparam int          EPOCH_W    = 8;
    localparam int          ROUNDS     = 6;
    localparam logic [31:0] HASH_INIT  = 32'h811C_9DC5;
    localparam logic [31:0] HASH_MUL   = 32'h9E37_79B1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef enum logic [1:0] {
        STAT_REUSED = 2'd0,
        STAT_NEW    = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        new_mesh;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
    } t_in_word;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        t_status           status;
    } t_out_word;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
    } t_vertex;

    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        t = (h ^ w) * HASH_MUL;
        return t ^ (t >> 15);
    endfunction

endpackage

// ----- hdl/vertex_dedup_indexer_core.sv -----
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core
// Maps a stream of vertices to dense indices of unique vertices per mesh.
// ----------------------------------------------------------------------------
// Each input word carries one vertex (six raw 32-bit patterns); the output
// word gives its dense index and whether it was reused, newly added or
// dropped because the table is full. Vertices live in one open-addressed
// hash table in a synchronous memory of CAPACITY entries with linear
// probing. Each item is accepted, hashed over ROUNDS rounds (one multiply per
// round), reduced to a slot directly when CAPACITY is a power of two or
// otherwise by reciprocal multiply, multiply-subtract and final correction,
// then read and probed at one probe per cycle (set by the single memory read
// port), up to CAPACITY probes when the table is full, and its result loads
// the output register once that register is free.
// A new-mesh word invalidates the table by advancing an epoch tag; after
// reset, and on every 255th new mesh when the tag wraps, a clearing pass over
// all CAPACITY entries runs before the item proceeds, during which no word is
// accepted.
module vertex_dedup_indexer_core #(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vdi_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vdi_pkg::t_out_word o_out_word
);
    import vdi_pkg::*;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_PAD = (SLOT_W > VIDX_W) ? SLOT_W : VIDX_W;
    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  LAST_PRB   = CNT_W'(CAPACITY - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CAPACITY - 1);
    localparam logic [SLOT_W:0]   CAP_REM    = (SLOT_W + 1)'(CAPACITY);
    localparam logic [2:0]        RND_LAST   = 3'(ROUNDS - 1);
    localparam logic [63:0]       RECIP_FULL = 64'h1_0000_0000 / 64'(CAPACITY);
    localparam logic [31:0]       RECIP      = RECIP_FULL[31:0];
    localparam logic [1:0]        MOD_LAST   = 2'd2;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [SLOT_W-1:0]  idx;
        t_vertex            vtx;
    } t_entry;

    t_entry mem [CAPACITY];

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_clr_addr;
    logic               r_clr_resume;
    logic [EPOCH_W-1:0] r_epoch;
    logic [CNT_W-1:0]   r_count;
    t_vertex            r_vtx;
    logic [31:0]        r_h;
    logic [2:0]         r_round;
    logic [1:0]         r_mod_ph;
    logic [SLOT_W:0]    r_qlo;
    logic [SLOT_W:0]    r_rem;
    logic [SLOT_W-1:0]  r_slot;
    logic [CNT_W-1:0]   r_probe;
    t_entry             r_rd;
    logic [SLOT_W-1:0]  r_res_idx;
    t_status            r_res_stat;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               in_fire;
    logic               out_free;
    logic               wrap_clear;
    logic [31:0]        h_word;
    logic [63:0]        recip_prod;
    logic [SLOT_W:0]    q_times_cap;
    logic [SLOT_W:0]    rem_fix;
    logic [SLOT_W-1:0]  slot_red;
    logic [SLOT_W-1:0]  slot_nxt;
    logic               slot_empty;
    logic               slot_hit;
    logic               probe_done;
    logic               probe_cont;
    logic               ins_en;
    logic [SLOT_W-1:0]  res_idx;
    t_status            res_stat;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    t_entry             wr_data;
    logic [IDX_PAD-1:0] idx_pad;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign wrap_clear = i_in_word.new_mesh && (r_epoch == EPOCH_MAX);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = r_clr_resume ? ST_HASH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = wrap_clear ? ST_CLEAR : ST_HASH;
                end
            end
            ST_HASH: begin
                if (r_round == RND_LAST) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (IS_POW2 || (r_mod_ph == MOD_LAST)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (probe_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);

        unique case (r_round)
            3'd0:    h_word = r_vtx.pos_x;
            3'd1:    h_word = r_vtx.pos_y;
            3'd2:    h_word = r_vtx.pos_z;
            3'd3:    h_word = r_vtx.norm_x;
            3'd4:    h_word = r_vtx.norm_y;
            3'd5:    h_word = r_vtx.norm_z;
            default: h_word = '0;
        endcase

        recip_prod  = {32'd0, r_h} * {32'd0, RECIP};
        q_times_cap = r_qlo * CAP_REM;
        rem_fix     = (r_rem >= CAP_REM) ? (r_rem - CAP_REM) : r_rem;
        slot_red    = IS_POW2 ? r_h[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];
        slot_nxt    = (r_slot == LAST_SLOT) ? '0 : (r_slot + 1'b1);

        slot_empty = (r_rd.tag != r_epoch);
        slot_hit   = !slot_empty && (r_rd.vtx == r_vtx);
        probe_done = slot_empty || slot_hit || (r_probe == LAST_PRB);
        probe_cont = (r_state == ST_CHECK) && !probe_done;
        ins_en     = (r_state == ST_CHECK) && slot_empty && (r_count < CAP_CNT);

        priority if (slot_empty && (r_count < CAP_CNT)) begin
            res_idx  = r_count[SLOT_W-1:0];
            res_stat = STAT_NEW;
        end else if (slot_hit) begin
            res_idx  = r_rd.idx;
            res_stat = STAT_REUSED;
        end else begin
            res_idx  = '0;
            res_stat = STAT_FULL;
        end

        rd_en   = (r_state == ST_READ) || probe_cont;
        rd_addr = (r_state == ST_READ) ? r_slot : slot_nxt;

        wr_en = (r_state == ST_CLEAR) || ins_en;
        if (r_state == ST_CLEAR) begin
            wr_addr     = r_clr_addr;
            wr_data     = '0;
        end else begin
            wr_addr     = r_slot;
            wr_data.tag = r_epoch;
            wr_data.idx = r_count[SLOT_W-1:0];
            wr_data.vtx = r_vtx;
        end

        idx_pad    = IDX_PAD'(r_res_idx);
        o_out_valid = r_out_valid;
        o_out_word  = r_out;
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_clr_resume <= 1'b0;
            r_epoch      <= EPOCH_W'(1);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                if (r_clr_addr == LAST_SLOT) begin
                    r_clr_addr <= '0;
                    r_epoch    <= EPOCH_W'(1);
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (in_fire && i_in_word.new_mesh) begin
                r_count      <= '0;
                r_clr_resume <= 1'b1;
                if (!wrap_clear) begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if (ins_en) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_vtx.pos_x  <= i_in_word.pos_x;
            r_vtx.pos_y  <= i_in_word.pos_y;
            r_vtx.pos_z  <= i_in_word.pos_z;
            r_vtx.norm_x <= i_in_word.norm_x;
            r_vtx.norm_y <= i_in_word.norm_y;
            r_vtx.norm_z <= i_in_word.norm_z;
            r_h          <= HASH_INIT;
            r_round      <= '0;
        end
        if (r_state == ST_HASH) begin
            r_h      <= mix_word(r_h, h_word);
            r_round  <= r_round + 1'b1;
            r_mod_ph <= '0;
        end
        if (r_state == ST_MOD) begin
            r_mod_ph <= r_mod_ph + 1'b1;
            r_qlo    <= recip_prod[32 +: SLOT_W+1];
            r_rem    <= r_h[SLOT_W:0] - q_times_cap;
            r_slot   <= slot_red;
            r_probe  <= '0;
        end
        if (probe_cont) begin
            r_slot  <= slot_nxt;
            r_probe <= r_probe + 1'b1;
        end
        if ((r_state == ST_CHECK) && probe_done) begin
            r_res_idx  <= res_idx;
            r_res_stat <= res_stat;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out.vertex_index <= idx_pad[VIDX_W-1:0];
            r_out.status       <= r_res_stat;
        end
    end

endmodule

// ----- tb/sv/tb_vertex_dedup_indexer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_dedup_indexer_core
// Self-checking bench for the vertex deduplication indexer.
// ----------------------------------------------------------------------------
// A directed table covers signed zeros, NaN patterns, all-ones fields and
// back-to-back new meshes. Random traffic then runs many short meshes with
// repeats, stale vertices and one-bit near misses, one mesh that fills the
// table and overflows it, and enough new meshes to wrap the epoch tag.
// Each result is checked against a per-mesh vertex map or a typed row.
// ----------------------------------------------------------------------------
module tb_vertex_dedup_indexer_core;
    import vdi_pkg::*;

    localparam int          CAPACITY     = 1024;
    localparam int          LIMIT_CYCLES = 8_000_000;
    localparam int          STALL_AT     = 100;
    localparam int          STALL_CYCLES = 300;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          ROW_N        = 24;
    localparam logic [31:0] ZERO         = 32'h0000_0000;
    localparam logic [31:0] ONES         = 32'hFFFF_FFFF;
    localparam logic [31:0] NEG_ZERO     = 32'h8000_0000;
    localparam logic [31:0] QNAN_A       = 32'h7FC0_0000;
    localparam logic [31:0] QNAN_B       = 32'h7FC0_0001;
    localparam logic [31:0] POS_INF      = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF      = 32'hFF80_0000;
    localparam logic [31:0] ONE_F        = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE_F    = 32'hBF80_0000;
    localparam logic [31:0] LSB_ONLY     = 32'h0000_0001;

    typedef struct packed {
        t_in_word  vin;
        logic      typed;
        t_out_word vout;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    logic [VIDX_W-1:0] mesh_index [bit [191:0]];
    int unsigned       unique_in_mesh = 0;
    bit [191:0]        recent_vertices [$];
    t_out_word         pending_results [$];
    int unsigned       mesh_starts    = 0;
    int unsigned       errors         = 0;
    int unsigned       results_seen   = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       stall_left     = 0;
    bit                stall_done     = 1'b0;
    bit                quiet          = 1'b0;
    t_row              directed_rows [ROW_N];

    vertex_dedup_indexer_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_out_word index_vertex(input t_in_word w);
        t_out_word  r;
        bit [191:0] key;
        if (w.new_mesh) begin
            mesh_index.delete();
            unique_in_mesh = 0;
        end
        key = w[191:0];
        if (mesh_index.exists(key)) begin
            r.vertex_index = mesh_index[key];
            r.status       = STAT_REUSED;
        end else if (unique_in_mesh >= CAPACITY) begin
            r.vertex_index = '0;
            r.status       = STAT_FULL;
        end else begin
            mesh_index[key] = unique_in_mesh[VIDX_W-1:0];
            r.vertex_index  = unique_in_mesh[VIDX_W-1:0];
            r.status        = STAT_NEW;
            unique_in_mesh++;
        end
        return r;
    endfunction

    function automatic t_in_word pick_vertex(input int unsigned reuse_pct);
        t_in_word    w;
        int unsigned sel;
        int unsigned bit_pos;
        w   = '0;
        sel = $urandom_range(99);
        if (recent_vertices.size() != 0 && sel < reuse_pct) begin
            w[191:0] = recent_vertices[$urandom_range(recent_vertices.size() - 1)];
            if ($urandom_range(2) == 0) begin
                bit_pos    = $urandom_range(191);
                w[bit_pos] = ~w[bit_pos];
            end
        end else begin
            for (int f = 0; f < 6; f++) begin
                if (sel < reuse_pct + 15 && $urandom_range(1) == 0) begin
                    case ($urandom_range(7))
                        0: w[32*f +: 32] = ZERO;
                        1: w[32*f +: 32] = NEG_ZERO;
                        2: w[32*f +: 32] = ONES;
                        3: w[32*f +: 32] = QNAN_A;
                        4: w[32*f +: 32] = POS_INF;
                        5: w[32*f +: 32] = NEG_INF;
                        6: w[32*f +: 32] = ONE_F;
                        default: w[32*f +: 32] = NEG_ONE_F;
                    endcase
                end else begin
                    w[32*f +: 32] = $urandom;
                end
            end
        end
        recent_vertices = {recent_vertices, w[191:0]};
        if (recent_vertices.size() > 48) recent_vertices.delete(0);
        return w;
    endfunction

    task automatic offer_vertex(input t_in_word w, input logic typed, input t_out_word typed_res);
        t_out_word res;
        while (!quiet && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        res = index_vertex(w);
        if (typed) res = typed_res;
        pending_results = {pending_results, res};
        if (w.new_mesh) mesh_starts++;
    endtask

    task automatic run_small_meshes(input int unsigned until_starts);
        t_in_word    w;
        int unsigned len;
        while (mesh_starts < until_starts) begin
            len = ($urandom_range(99) < 85) ? 1 : $urandom_range(2, 4);
            for (int unsigned k = 0; k < len; k++) begin
                w          = pick_vertex(45);
                w.new_mesh = (k == 0) || ($urandom_range(99) < 4);
                offer_vertex(w, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AT) begin
            out_ready  <= 1'b0;
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else begin
            out_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual index %0d status %0d",
                         $time, out_word.vertex_index, out_word.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_word.vertex_index !== want.vertex_index) begin
                    $display("%0t: vertex_index mismatch, expected %0d, actual %0d",
                             $time, want.vertex_index, out_word.vertex_index);
                    errors++;
                end
                if (out_word.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, out_word.status);
                    errors++;
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_word w;
        directed_rows = '{
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_REUSED},
            {1'b0, NEG_ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd1, STAT_NEW},
            {1'b0, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1, 10'd2, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_REUSED},
            {1'b0, ZERO, ZERO, ZERO, ZERO, QNAN_A, ZERO, 1'b1, 10'd3, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, QNAN_B, ZERO, 1'b1, 10'd4, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, QNAN_A, ZERO, 1'b1, 10'd3, STAT_REUSED},
            {1'b0, NEG_ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd1, STAT_REUSED},
            {1'b0, ONE_F, NEG_ONE_F, ZERO, ZERO, ONE_F, ZERO, 1'b0, 10'd0, STAT_REUSED},
            {1'b0, ZERO, ZERO, POS_INF, ZERO, ZERO, NEG_INF, 1'b0, 10'd0, STAT_REUSED},
            {1'b0, ONE_F, NEG_ONE_F, ZERO, ZERO, ONE_F, ZERO, 1'b0, 10'd0, STAT_REUSED},
            {1'b1, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1, 10'd0, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd1, STAT_NEW},
            {1'b0, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1, 10'd0, STAT_REUSED},
            {1'b1, ONES, ONES, ONES, ONES, ONES, ONES, 1'b1, 10'd0, STAT_NEW},
            {1'b1, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_NEW},
            {1'b1, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd0, STAT_REUSED},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, LSB_ONLY, 1'b1, 10'd1, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, LSB_ONLY, ZERO, ZERO, 1'b1, 10'd2, STAT_NEW},
            {1'b0, ZERO, ZERO, NEG_ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd3, STAT_NEW},
            {1'b0, ZERO, ZERO, ZERO, ZERO, ZERO, LSB_ONLY, 1'b1, 10'd1, STAT_REUSED},
            {1'b0, ZERO, NEG_ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 10'd4, STAT_NEW}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            offer_vertex(directed_rows[r].vin, directed_rows[r].typed, directed_rows[r].vout);
        end

        run_small_meshes(120);

        // fill one mesh to capacity, then overflow it
        w          = pick_vertex(0);
        w.new_mesh = 1'b1;
        offer_vertex(w, 1'b0, '0);
        while (unique_in_mesh < CAPACITY) begin
            quiet = (unique_in_mesh >= 300 && unique_in_mesh < 600);
            offer_vertex(pick_vertex(4), 1'b0, '0);
        end
        quiet = 1'b0;
        for (int k = 0; k < 24; k++) begin
            offer_vertex(pick_vertex(50), 1'b0, '0);
        end

        // cross the epoch wrap
        run_small_meshes(280);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
